/* sv/lcsi_pkg.sv */
package lcsi_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_SET_W  = 8;
    localparam int CNT_W      = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_MASK  = 2'd1,
        CFG_WAYS_IN_USE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0]  offset_bits;
        logic [31:0] index_mask;
        logic [3:0]  ways_in_use;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        offset_bits: 5'd2,
        index_mask:  32'd1020,
        ways_in_use: 4'd8
    };

    typedef enum logic [1:0] {
        S_CLR,
        S_IDLE,
        S_IDX,
        S_UPD
    } t_state;

endpackage

/* sv/lcsi_ram.sv */
module lcsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/lcsi_index.sv */
module lcsi_index #(
    parameter int ADDR_SIZE = 32,
    parameter int SETS      = 256,
    parameter int SET_W     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_addr,
    input  lcsi_pkg::t_cfg       i_cfg,
    output logic                 o_done,
    output logic [SET_W-1:0]     o_set
);

    localparam logic [31:0] AMASK = (ADDR_SIZE >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << ADDR_SIZE) - 64'd1);
    localparam bit POW2 = ((SETS & (SETS - 1)) == 0);
    localparam int NSTEP = POW2 ? 0 : 4;
    localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);
    localparam logic [SET_W:0]   SETS_X   = (SET_W + 1)'(SETS);

    logic [31:0]      em;
    logic [5:0]       pos [32];
    logic [31:0]      gathered;
    logic [SET_W-1:0] n_rem;
    logic [SET_W:0]   rem_t;

    logic [31:0]      r_acc;
    logic [SET_W-1:0] r_rem;
    logic [2:0]       r_cnt;
    logic             r_busy;

    // bit k lands at the count of selected bits below it
    always_comb begin
        em = i_cfg.index_mask & AMASK & (32'hFFFF_FFFF << i_cfg.offset_bits);
        for (int k = 0; k < 32; k++) begin
            pos[k] = 6'($countones(em & ((32'd1 << k) - 32'd1)));
        end
        gathered = '0;
        for (int j = 0; j < 32; j++) begin
            for (int k = 0; k < 32; k++) begin
                if (em[k] && i_addr[k] && pos[k] == 6'(j)) begin
                    gathered[j] = 1'b1;
                end
            end
        end
    end

    // remainder mod sets, eight gathered bits per cycle from the top
    always_comb begin
        n_rem = r_rem;
        rem_t = '0;
        for (int b = 7; b >= 0; b--) begin
            rem_t = {n_rem, r_acc[24 + b]};
            if (rem_t >= SETS_X) begin
                rem_t = rem_t - SETS_X;
            end
            n_rem = rem_t[SET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 3'(NSTEP)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= gathered;
            r_rem <= '0;
        end else if (r_busy && r_cnt != 3'(NSTEP)) begin
            r_acc <= r_acc << 8;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_cnt == 3'(NSTEP));
    assign o_set  = POW2 ? (r_acc[SET_W-1:0] & SET_MASK) : r_rem;

endmodule

/* sv/lcsi_lru.sv */
module lcsi_lru #(
    parameter int WAYS   = 8,
    parameter int RANK_W = 3
) (
    input  logic [WAYS-1:0][31:0]         i_tags,
    input  logic [WAYS-1:0]               i_valid,
    input  logic [WAYS-1:0][RANK_W-1:0]   i_rank,
    input  logic [31:0]                   i_block,
    input  logic [3:0]                    i_ways_in_use,
    output logic                          o_hit,
    output logic [WAYS-1:0][31:0]         o_tags,
    output logic [WAYS-1:0]               o_valid,
    output logic [WAYS-1:0][RANK_W-1:0]   o_rank
);

    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   hit_oh;
    logic [WAYS-1:0]   keep;
    logic [WAYS-1:0]   slot_oh;
    logic [RANK_W-1:0] hit_rank;
    logic [7:0]        lim;
    logic [7:0]        evict_rank;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = i_valid[w] && (i_tags[w] == i_block);
        end
        // lowest matching way wins
        hit_oh = match & (~match + WAYS'(1));
        o_hit  = |match;

        hit_rank = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) begin
                hit_rank = hit_rank | i_rank[w];
            end
        end

        if (i_ways_in_use == 4'd0) begin
            lim = 8'd1;
        end else if (8'(i_ways_in_use) > 8'(WAYS)) begin
            lim = 8'(WAYS);
        end else begin
            lim = 8'(i_ways_in_use);
        end
        evict_rank = lim - 8'd1;

        // on a miss, drop every line at or past the oldest allowed rank
        for (int w = 0; w < WAYS; w++) begin
            keep[w] = i_valid[w] && (8'(i_rank[w]) < evict_rank);
        end
        slot_oh = ~keep & (keep + WAYS'(1));

        for (int w = 0; w < WAYS; w++) begin
            if (o_hit) begin
                o_valid[w] = i_valid[w];
                o_tags[w]  = i_tags[w];
                if (hit_oh[w]) begin
                    o_rank[w] = '0;
                end else if (i_valid[w] && i_rank[w] < hit_rank) begin
                    o_rank[w] = i_rank[w] + RANK_W'(1);
                end else begin
                    o_rank[w] = i_rank[w];
                end
            end else begin
                o_valid[w] = keep[w] | slot_oh[w];
                o_tags[w]  = slot_oh[w] ? i_block : i_tags[w];
                if (slot_oh[w]) begin
                    o_rank[w] = '0;
                end else if (keep[w]) begin
                    o_rank[w] = i_rank[w] + RANK_W'(1);
                end else begin
                    o_rank[w] = i_rank[w];
                end
            end
        end
    end

endmodule

/* sv/lru_cache_with_selected_index_bits_unit.sv */
// an accepted item passes the index state, then the update state, where its result is
// registered; if SETS is not a power of two, extra steps reduce the index mod SETS
// the tag and line-state memories of an item's set are read, then written back before the
// next item's read; a new item is taken at write-back, which output back-pressure holds
// reset: control state and counters clear at once; then a clearing pass over all SETS
// entries zeroes the line-state memory, during which no item is accepted

module lru_cache_with_selected_index_bits_unit #(
    parameter int ADDR_SIZE = 32,
    parameter int SETS      = 256,
    parameter int WAYS      = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // address[31:0]
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [lcsi_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // hit[0], set_index[8:1], hits_so_far[40:9], misses_so_far[72:41], zero[79:73]
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [lcsi_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [lcsi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lcsi_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int META_W = WAYS * (1 + RANK_W);
    localparam int TROW_W = WAYS * lcsi_pkg::TAG_W;
    localparam logic [31:0] AMASK = (ADDR_SIZE >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << ADDR_SIZE) - 64'd1);

    lcsi_pkg::t_cfg   r_cfg;
    lcsi_pkg::t_state r_state;
    lcsi_pkg::t_state n_state;

    logic [SET_W-1:0] r_clr;
    logic [SET_W-1:0] r_set;
    logic [31:0]      r_block;
    logic             r_ovalid;
    logic             r_hit;
    logic [lcsi_pkg::OUT_SET_W-1:0] r_set8;
    logic [lcsi_pkg::CNT_W-1:0]     r_hits;
    logic [lcsi_pkg::CNT_W-1:0]     r_misses;

    logic             in_accept;
    logic             in_ready;
    logic             upd_fire;
    logic             mem_re;
    logic             meta_we;
    logic             tag_we;
    logic [SET_W-1:0] meta_waddr;
    logic [META_W-1:0] meta_wdata;
    logic [META_W-1:0] meta_rdata;
    logic [TROW_W-1:0] tag_rdata;

    logic             idx_done;
    logic [SET_W-1:0] idx_set;
    logic [lcsi_pkg::ADDR_W-1:0] in_addr;
    logic [31:0]      set_x;

    logic [WAYS-1:0][31:0]       rd_tags;
    logic [WAYS-1:0]             rd_valid;
    logic [WAYS-1:0][RANK_W-1:0] rd_rank;
    logic                        lru_hit;
    logic [WAYS-1:0][31:0]       wr_tags;
    logic [WAYS-1:0]             wr_valid;
    logic [WAYS-1:0][RANK_W-1:0] wr_rank;

    assign in_addr   = i_s_axis_tdata[31:0] & AMASK;
    assign in_accept = i_s_axis_tvalid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lcsi_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (lcsi_pkg::t_cfg_idx'(i_cfg_idx))
                lcsi_pkg::CFG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_wdata[4:0];
                lcsi_pkg::CFG_INDEX_MASK:  r_cfg.index_mask  <= i_cfg_wdata[31:0];
                lcsi_pkg::CFG_WAYS_IN_USE: r_cfg.ways_in_use <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    lcsi_index #(
        .ADDR_SIZE (ADDR_SIZE),
        .SETS      (SETS),
        .SET_W     (SET_W)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_addr  (in_addr),
        .i_cfg   (r_cfg),
        .o_done  (idx_done),
        .o_set   (idx_set)
    );

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        upd_fire = 1'b0;
        mem_re   = 1'b0;
        meta_we  = 1'b0;
        tag_we   = 1'b0;
        unique case (r_state)
            lcsi_pkg::S_CLR: begin
                meta_we = 1'b1;
                if (r_clr == SET_W'(SETS - 1)) begin
                    n_state = lcsi_pkg::S_IDLE;
                end
            end
            lcsi_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = lcsi_pkg::S_IDX;
                end
            end
            lcsi_pkg::S_IDX: begin
                if (idx_done) begin
                    mem_re  = 1'b1;
                    n_state = lcsi_pkg::S_UPD;
                end
            end
            lcsi_pkg::S_UPD: begin
                // the write-back lands before the next item's read is issued
                if (!r_ovalid || i_m_axis_tready) begin
                    upd_fire = 1'b1;
                    meta_we  = 1'b1;
                    tag_we   = !lru_hit;
                    in_ready = 1'b1;
                    n_state  = i_s_axis_tvalid ? lcsi_pkg::S_IDX : lcsi_pkg::S_IDLE;
                end
            end
            default: n_state = lcsi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lcsi_pkg::S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lcsi_pkg::S_CLR) begin
                r_clr <= r_clr + SET_W'(1);
            end
            if (upd_fire) begin
                r_ovalid <= 1'b1;
                if (lru_hit) begin
                    r_hits <= r_hits + 32'd1;
                end else begin
                    r_misses <= r_misses + 32'd1;
                end
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign set_x = 32'(r_set);

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_block <= in_addr >> r_cfg.offset_bits;
        end
        if (mem_re) begin
            r_set <= idx_set;
        end
        if (upd_fire) begin
            r_hit  <= lru_hit;
            r_set8 <= set_x[7:0];
        end
    end

    assign meta_waddr = (r_state == lcsi_pkg::S_CLR) ? r_clr : r_set;
    assign meta_wdata = (r_state == lcsi_pkg::S_CLR) ? '0 : {wr_rank, wr_valid};

    lcsi_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS),
        .AW    (SET_W)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (mem_re),
        .i_raddr (idx_set),
        .o_rdata (meta_rdata)
    );

    lcsi_ram #(
        .WIDTH (TROW_W),
        .DEPTH (SETS),
        .AW    (SET_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_set),
        .i_wdata (wr_tags),
        .i_re    (mem_re),
        .i_raddr (idx_set),
        .o_rdata (tag_rdata)
    );

    assign rd_tags  = tag_rdata;
    assign rd_valid = meta_rdata[WAYS-1:0];
    assign rd_rank  = meta_rdata[META_W-1:WAYS];

    lcsi_lru #(
        .WAYS   (WAYS),
        .RANK_W (RANK_W)
    ) u_lru (
        .i_tags        (rd_tags),
        .i_valid       (rd_valid),
        .i_rank        (rd_rank),
        .i_block       (r_block),
        .i_ways_in_use (r_cfg.ways_in_use),
        .o_hit         (lru_hit),
        .o_tags        (wr_tags),
        .o_valid       (wr_valid),
        .o_rank        (wr_rank)
    );

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_misses, r_hits, r_set8, r_hit};

`ifndef SYNTHESIS
    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcsi_pkg::S_CLR) |-> !o_s_axis_tready)
        else $error("item accepted during clearing pass");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_re && meta_we))
        else $error("line-state read and write in the same cycle");

    a_one_count_per_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> (32'(r_hits + r_misses) ==
                      32'($past(r_hits) + $past(r_misses) + 32'd1)))
        else $error("counters did not advance by exactly one");

    a_done_in_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idx_done |-> (r_state == lcsi_pkg::S_IDX))
        else $error("set index ready outside the index state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_m_axis_tready) |-> !upd_fire)
        else $error("result register overwritten before it was taken");
`endif

endmodule

/* sim/tb_lru_cache_with_selected_index_bits_unit.sv */
module tb_lru_cache_with_selected_index_bits_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NSETS       = 256;
    localparam int          NWAYS       = 8;
    localparam int          NPHASE      = 12;
    localparam int          PHASE_ITEMS = 75;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 200;
    localparam int          NDIR        = 32;
    localparam logic [1:0]  IDX_NONE        = 2'd0;
    localparam logic [1:0]  CFG_UNUSED_IDX  = 2'd3;

    typedef struct packed {
        logic        hit;
        logic [7:0]  sidx;
        logic [31:0] hits;
        logic [31:0] misses;
    } t_lookup;

    typedef enum logic {ROW_ACC, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [31:0] val;
        logic        typed;
        t_lookup     want;
    } t_dir_row;

    // val is the address for an access row, the register value for a write row
    localparam t_dir_row DIR_TAB [NDIR] = '{
        '{ROW_ACC, IDX_NONE, 32'h0000_0000, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd1}},
        '{ROW_ACC, IDX_NONE, 32'h0000_0000, 1'b1, '{1'b1, 8'h00, 32'd1, 32'd1}},
        '{ROW_ACC, IDX_NONE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 8'hFF, 32'd1, 32'd2}},
        '{ROW_ACC, IDX_NONE, 32'h0000_0003, 1'b1, '{1'b1, 8'h00, 32'd2, 32'd2}},
        // fill set zero past its ways so the first line is evicted
        '{ROW_ACC, IDX_NONE, 32'h0000_0400, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_0800, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_0C00, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_1000, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_1400, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_1800, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_1C00, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_2000, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_0000, 1'b0, '0},
        // set now fuller than the ways in use
        '{ROW_CFG, lcsi_pkg::CFG_WAYS_IN_USE, 32'd2, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_4000, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_2000, 1'b0, '0},
        '{ROW_CFG, lcsi_pkg::CFG_OFFSET_BITS, 32'd31, 1'b0, '0},
        '{ROW_CFG, lcsi_pkg::CFG_INDEX_MASK, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h8000_0000, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h7FFF_FFFF, 1'b0, '0},
        // every address bit selected, more than the index can hold
        '{ROW_CFG, lcsi_pkg::CFG_OFFSET_BITS, 32'd0, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h1234_5678, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_CFG, lcsi_pkg::CFG_INDEX_MASK, 32'h0000_0000, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'hAAAA_AAAA, 1'b0, '0},
        // zero ways behaves as one
        '{ROW_CFG, lcsi_pkg::CFG_WAYS_IN_USE, 32'd0, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_5555, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_AAAA, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_5555, 1'b0, '0},
        '{ROW_CFG, lcsi_pkg::CFG_WAYS_IN_USE, 32'd15, 1'b0, '0},
        '{ROW_CFG, CFG_UNUSED_IDX, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_ACC, IDX_NONE, 32'h0000_0001, 1'b0, '0}
    };

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [lcsi_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [lcsi_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                             i_cfg_we = 1'b0;
    logic [lcsi_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [lcsi_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    lru_cache_with_selected_index_bits_unit #(
        .ADDR_SIZE(32),
        .SETS     (NSETS),
        .WAYS     (NWAYS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // cache shadow: config, tags, line state, counters
    logic [4:0]  m_offs = lcsi_pkg::CFG_RESET.offset_bits;
    logic [31:0] m_mask = lcsi_pkg::CFG_RESET.index_mask;
    logic [3:0]  m_ways = lcsi_pkg::CFG_RESET.ways_in_use;
    logic [31:0] tag_mem  [NSETS*NWAYS];
    logic        line_ok  [NSETS*NWAYS];
    logic [2:0]  age      [NSETS*NWAYS];
    logic [31:0] hit_total  = '0;
    logic [31:0] miss_total = '0;

    t_lookup     lookup_q [$];
    logic [31:0] hot_addr [16];
    bit          gaps_on = 1'b1;
    int          err_cnt = 0;
    int          n_acc = 0;
    int          n_regw = 0;
    int          n_res = 0;
    int          n_hit = 0;
    int          cyc = 0;
    int          stall_left = 0;
    bit          held = 1'b0;

    initial begin
        for (int i = 0; i < NSETS*NWAYS; i++) begin
            tag_mem[i] = '0;
            line_ok[i] = 1'b0;
            age[i]     = '0;
        end
    end

    task automatic report_mismatch(input string fld, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("tb: result %0d %s mismatch: got %h want %h", n_res, fld, got, exp);
        err_cnt++;
    endtask

    function automatic void apply_cfg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            lcsi_pkg::CFG_OFFSET_BITS: m_offs = val[4:0];
            lcsi_pkg::CFG_INDEX_MASK:  m_mask = val;
            lcsi_pkg::CFG_WAYS_IN_USE: m_ways = val[3:0];
            default: ;
        endcase
    endfunction

    function automatic t_lookup cache_lookup(input logic [31:0] a);
        t_lookup     r;
        logic [31:0] blk;
        logic [31:0] acc;
        logic [2:0]  rr;
        int          base;
        int          found;
        int          slot;
        int          lim;
        blk = a >> m_offs;
        acc = '0;
        // gather selected bits, highest address bit ends up most significant
        for (int k = 31; k >= 0; k--)
            if (k >= int'(m_offs) && m_mask[k])
                acc = {acc[30:0], a[k]};
        r.sidx = acc[7:0];
        base = int'(r.sidx) * NWAYS;
        lim = int'(m_ways);
        if (lim < 1) lim = 1;
        if (lim > NWAYS) lim = NWAYS;
        found = -1;
        for (int w = 0; w < NWAYS; w++)
            if (found < 0 && line_ok[base+w] && tag_mem[base+w] == blk)
                found = w;
        if (found >= 0) begin
            rr = age[base+found];
            for (int w = 0; w < NWAYS; w++)
                if (line_ok[base+w] && age[base+w] < rr)
                    age[base+w] = age[base+w] + 3'd1;
            age[base+found] = '0;
            hit_total = hit_total + 32'd1;
            r.hit = 1'b1;
        end else begin
            slot = -1;
            for (int w = 0; w < NWAYS; w++)
                if (line_ok[base+w] && int'(age[base+w]) >= lim - 1)
                    line_ok[base+w] = 1'b0;
            for (int w = 0; w < NWAYS; w++) begin
                if (line_ok[base+w])
                    age[base+w] = age[base+w] + 3'd1;
                else if (slot < 0)
                    slot = w;
            end
            if (slot >= 0) begin
                tag_mem[base+slot] = blk;
                line_ok[base+slot] = 1'b1;
                age[base+slot]     = '0;
            end
            miss_total = miss_total + 32'd1;
            r.hit = 1'b0;
        end
        r.hits   = hit_total;
        r.misses = miss_total;
        return r;
    endfunction

    // mostly reuse of a small working set, half of it aliasing into one set
    function automatic logic [31:0] pick_addr();
        int          r;
        logic [31:0] a;
        logic [31:0] lowm;
        r = $urandom_range(99);
        a = hot_addr[$urandom_range(15)];
        lowm = (32'd1 << m_offs) - 32'd1;
        if (r < 55)
            return a;
        else if (r < 75)
            return a ^ ($urandom & lowm);
        else if (r < 85)
            return a ^ (32'd1 << $urandom_range(31));
        else
            return $urandom;
    endfunction

    task automatic refill_hot();
        logic [31:0] base;
        base = $urandom;
        for (int i = 0; i < 16; i++)
            hot_addr[i] = (i % 2 == 0) ? (($urandom & ~m_mask) | (base & m_mask)) : $urandom;
    endtask

    task automatic drive_addr(input logic [31:0] a, input bit given, input t_lookup want);
        t_lookup p;
        while (gaps_on && $urandom_range(99) < 13) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= a;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        p = cache_lookup(a);
        lookup_q.insert(lookup_q.size(), given ? want : p);
        n_acc++;
    endtask

    // sender goes quiet until every pending result is back
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves the write enable high; caller lowers it after the last write
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        apply_cfg(idx, val);
        n_regw++;
    endtask

    // receiver: random back-pressure, one long hold, one stretch with none
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (lookup_q.size() == 0) begin
                    report_mismatch("unexpected item", o_m_axis_tdata[31:0], '0);
                end else begin
                    t_lookup want;
                    want = lookup_q.pop_front();
                    if (o_m_axis_tdata[0] !== want.hit)
                        report_mismatch("hit", 32'(o_m_axis_tdata[0]), 32'(want.hit));
                    if (o_m_axis_tdata[8:1] !== want.sidx)
                        report_mismatch("set_index", 32'(o_m_axis_tdata[8:1]),
                                        32'(want.sidx));
                    if (o_m_axis_tdata[40:9] !== want.hits)
                        report_mismatch("hits_so_far", o_m_axis_tdata[40:9], want.hits);
                    if (o_m_axis_tdata[72:41] !== want.misses)
                        report_mismatch("misses_so_far", o_m_axis_tdata[72:41],
                                        want.misses);
                end
                if (o_m_axis_tdata[0] === 1'b1) n_hit++;
                n_res++;
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (n_res >= 400 && !held) begin
                held <= 1'b1;
                stall_left <= HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= (n_res >= 500 && n_res < 650) ||
                                   ($urandom_range(99) >= 13);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [4:0]  o;
        logic [31:0] m;
        logic [3:0]  w;
        int          lo;
        int          wd;
        bit          cfg_open;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_open = 1'b0;
        for (int i = 0; i < NDIR; i++) begin
            if (DIR_TAB[i].kind == ROW_CFG) begin
                if (!cfg_open) settle();
                cfg_open = 1'b1;
                reg_write(DIR_TAB[i].idx, DIR_TAB[i].val);
            end else begin
                if (cfg_open) i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
                drive_addr(DIR_TAB[i].val, DIR_TAB[i].typed, DIR_TAB[i].want);
            end
        end

        for (int ph = 0; ph < NPHASE; ph++) begin
            case (ph)
                0: begin o = 5'd2;  m = 32'h0000_03FC; w = 4'd8;  end
                1: begin o = 5'd2;  m = 32'h0000_03FC; w = 4'd1;  end
                2: begin o = 5'd0;  m = 32'hFFFF_FFFF; w = 4'd8;  end
                3: begin o = 5'd31; m = 32'hFFFF_FFFF; w = 4'd4;  end
                4: begin o = 5'd5;  m = 32'h0000_0000; w = 4'd2;  end
                5: begin o = 5'd4;  m = 32'h0000_0FF0; w = 4'd15; end
                default: begin
                    o = ($urandom_range(9) == 0) ? 5'd31 : 5'($urandom_range(8));
                    case ($urandom_range(2))
                        0: m = $urandom;
                        1: begin
                            lo = int'(o) + $urandom_range(3);
                            wd = $urandom_range(1, 10);
                            m = 32'(((64'd1 << wd) - 64'd1) << lo);
                        end
                        default: begin
                            m = '0;
                            repeat (8) m = m | (32'd1 << $urandom_range(31));
                        end
                    endcase
                    w = 4'($urandom_range(15));
                end
            endcase
            settle();
            reg_write(lcsi_pkg::CFG_OFFSET_BITS, 32'(o));
            reg_write(lcsi_pkg::CFG_INDEX_MASK, m);
            reg_write(lcsi_pkg::CFG_WAYS_IN_USE, 32'(w));
            if (ph == 7) reg_write(CFG_UNUSED_IDX, $urandom);
            i_cfg_we <= 1'b0;
            refill_hot();
            gaps_on = (ph != 5);
            repeat (PHASE_ITEMS) drive_addr(pick_addr(), 1'b0, '0);
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("tb: %0d accesses, %0d register writes over %0d settings", n_acc, n_regw,
                 NPHASE + 1);
        $display("tb: %0d results checked, %0d hits, one long output hold", n_res, n_hit);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
sv/lcsi_pkg.sv
sv/lcsi_ram.sv
sv/lcsi_index.sv
sv/lcsi_lru.sv
sv/lru_cache_with_selected_index_bits_unit.sv
sim/tb_lru_cache_with_selected_index_bits_unit.sv
